[src/natural_log_series_core_defines.svh]
`ifndef NATURAL_LOG_SERIES_CORE_DEFINES_SVH
`define NATURAL_LOG_SERIES_CORE_DEFINES_SVH

// Check c whenever a holds, same edge.
`define NLS_ASSERT_SAME(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("nls: check failed");

// Check c at the next edge after a holds.
`define NLS_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("nls: check failed");

`endif

[src/nls_pkg.sv]
`default_nettype none
package nls_pkg;

	localparam int QBITS = 32;
	localparam int NTERMS = 6;

	typedef struct packed {
		logic        valid;
		logic        zero;
		logic [16:0] rem;
		logic [16:0] den;
		logic [31:0] quo;
	} div_t;

	typedef struct packed {
		logic               valid;
		logic signed [32:0] x2;
		logic signed [32:0] pw;
		logic signed [35:0] sum;
	} term_t;

	localparam logic [30:0] COEF [NTERMS] = '{
		31'd715827876, 31'd429496730, 31'd306783372,
		31'd238609292, 31'd195225784, 31'd165191056
	};

	// round a 62-fraction-bit product to 31 fraction bits, ties away from zero
	function automatic logic signed [32:0] rnd31(input logic signed [65:0] p);
		logic [65:0] m;
		logic [65:0] r;
		logic [32:0] a;
		m = p[65] ? 66'(-p) : 66'(p);
		r = (m + (66'd1 << 30)) >> 31;
		a = r[32:0];
		rnd31 = p[65] ? $signed(-a) : $signed(a);
	endfunction

endpackage
`default_nettype wire

[src/nls_in_if.sv]
`default_nettype none
interface nls_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] operand;

	modport source (output valid, output operand, input ready);
	modport sink (input valid, input operand, output ready);
endinterface
`default_nettype wire

[src/nls_out_if.sv]
`default_nettype none
interface nls_out_if;
	logic               valid;
	logic               ready;
	logic signed [30:0] log_value;

	modport source (output valid, output log_value, input ready);
	modport sink (input valid, input log_value, output ready);
endinterface
`default_nettype wire

[src/nls_div_cell.sv]
`default_nettype none
module nls_div_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  nls_pkg::div_t      d,
	output nls_pkg::div_t      q
);
	import nls_pkg::*;

	logic [17:0] r2;
	logic [17:0] diff;
	logic        take;

	always_comb begin
		r2   = {d.rem, 1'b0};
		diff = r2 - {1'b0, d.den};
		take = r2 >= {1'b0, d.den};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q.valid <= d.valid;
			q.zero  <= d.zero;
			q.den   <= d.den;
			q.rem   <= take ? diff[16:0] : r2[16:0];
			q.quo   <= {d.quo[30:0], take};
		end
	end
endmodule
`default_nettype wire

[src/nls_term_cell.sv]
`default_nettype none
module nls_term_cell #(
	parameter int K = 0
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  nls_pkg::term_t d,
	output nls_pkg::term_t q
);
	import nls_pkg::*;

	logic               v_s1, v_s2, v_s3;
	logic signed [65:0] p1_s1, p2_s3;
	logic signed [32:0] x2_s1, x2_s2, x2_s3;
	logic signed [32:0] pw_s2, pw_s3;
	logic signed [35:0] sum_s1, sum_s2, sum_s3;
	logic signed [32:0] cf;

	assign cf = $signed({2'b00, COEF[K]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			q    <= '0;
		end else if (en) begin
			v_s1   <= d.valid;
			p1_s1  <= 66'(d.pw) * 66'(d.x2);
			x2_s1  <= d.x2;
			sum_s1 <= d.sum;

			v_s2   <= v_s1;
			pw_s2  <= rnd31(p1_s1);
			x2_s2  <= x2_s1;
			sum_s2 <= sum_s1;

			v_s3   <= v_s2;
			p2_s3  <= 66'(pw_s2) * 66'(cf);
			pw_s3  <= pw_s2;
			x2_s3  <= x2_s2;
			sum_s3 <= sum_s2;

			q.valid <= v_s3;
			q.pw    <= pw_s3;
			q.x2    <= x2_s3;
			q.sum   <= sum_s3 + 36'(rnd31(p2_s3));
		end
	end
endmodule
`default_nettype wire

[src/natural_log_series_core.sv]
// natural_log_series_core: ln(n) by the truncated atanh series.
// req carries a 16-bit unsigned operand n; rsp returns log_value, the
// approximate ln(n) as signed Q3.28 in a 31-bit word.
// Each word on req yields exactly one word on rsp, in order.
// From accept to rsp.valid a word passes 1 input stage,
// 32 restoring divide cells for x = (n-1)/(n+1), 2 stages for x and x^2,
// six series cells of 4 stages each, and 1 output register.
// Throughput: one word per cycle; every stage is a register of the chain.
// The rate is set by the pipeline advancing as one: when rsp holds a word
// that is not taken, the whole chain holds and req.ready drops.
// req.ready is high whenever the output register is empty or being taken.
// Reset clears all valid flags; the chain comes up empty and ready.
// n = 0 gives about -3.91 (x = -1); n = 1 gives 0.
`default_nettype none
`include "natural_log_series_core_defines.svh"
module natural_log_series_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	nls_in_if.sink     req,
	nls_out_if.source  rsp
);
	import nls_pkg::*;

	logic               adv;
	div_t               dv [QBITS+1];
	term_t              tc [NTERMS+1];
	logic [32:0]        qr;
	logic signed [32:0] x;
	logic               v_s1;
	logic signed [32:0] x_s1;
	logic signed [65:0] p_s1;
	logic signed [35:0] fs;
	logic [35:0]        fm;
	logic [35:0]        fr;
	logic signed [35:0] res;
	logic signed [30:0] sat;

	assign adv       = !rsp.valid || rsp.ready;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv[0] <= '0;
		end else if (adv) begin
			dv[0].valid <= req.valid;
			dv[0].zero  <= req.operand == 16'd0;
			dv[0].rem   <= (req.operand == 16'd0) ? 17'd0 : 17'(req.operand) - 17'd1;
			dv[0].den   <= 17'(req.operand) + 17'd1;
			dv[0].quo   <= '0;
		end
	end

	for (genvar i = 0; i < QBITS; i++) begin : g_div
		nls_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.d      (dv[i]),
			.q      (dv[i+1])
		);
	end

	always_comb begin
		qr = ({1'b0, dv[QBITS].quo} + 33'd1) >> 1;
		x  = dv[QBITS].zero ? -33'sd2147483648 : $signed(qr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			tc[0] <= '0;
		end else if (adv) begin
			v_s1        <= dv[QBITS].valid;
			x_s1        <= x;
			p_s1        <= 66'(x) * 66'(x);
			tc[0].valid <= v_s1;
			tc[0].x2    <= rnd31(p_s1);
			tc[0].pw    <= x_s1;
			tc[0].sum   <= 36'(x_s1);
		end
	end

	for (genvar k = 0; k < NTERMS; k++) begin : g_term
		nls_term_cell #(.K(k)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.d      (tc[k]),
			.q      (tc[k+1])
		);
	end

	always_comb begin
		fs  = tc[NTERMS].sum;
		fm  = fs[35] ? 36'(-fs) : 36'(fs);
		fr  = (fm + 36'd2) >> 2;
		res = fs[35] ? $signed(-fr) : $signed(fr);
		if (res > 36'sd1073741823) begin
			sat = 31'sh3FFFFFFF;
		end else if (res < -36'sd1073741824) begin
			sat = 31'sh40000000;
		end else begin
			sat = res[30:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (adv) begin
			rsp.valid     <= tc[NTERMS].valid;
			rsp.log_value <= sat;
		end
	end

	`NLS_ASSERT_SAME(a_div_rem, dv[QBITS].valid, dv[QBITS].rem < dv[QBITS].den)
	`NLS_ASSERT_SAME(a_x2_pos, tc[0].valid, !tc[0].x2[32])
	`NLS_ASSERT_NEXT(a_hold, rsp.valid && !rsp.ready, $stable(tc[NTERMS]))
endmodule
`default_nettype wire

[tb/sv/natural_log_series_checker.sv]
`timescale 1ns / 100ps
module natural_log_series_checker (
	input  wire logic  clk,
	input  wire logic  arst_n,
	nls_in_if          req,
	nls_out_if         rsp,
	output int         fail_count,
	output int         pending_count
);
	import nls_pkg::*;

	logic signed [30:0] log_queue[$];

	function automatic longint round_away(input longint v, input int s);
		longint m;
		m = (v < 0) ? -v : v;
		m = (m + (64'sd1 <<< (s - 1))) >>> s;
		return (v < 0) ? -m : m;
	endfunction

	function automatic logic signed [30:0] series_log(input logic [15:0] n);
		longint den, mag, q, x, x2, pw, sum, res;
		den = longint'(n) + 1;
		mag = (n == 16'd0) ? 1 : longint'(n) - 1;
		q = ((mag <<< 31) + den / 2) / den;
		x = (n == 16'd0) ? -q : q;
		x2 = round_away(x * x, 31);
		pw = x;
		sum = x;
		for (int k = 0; k < NTERMS; k++) begin
			pw = round_away(pw * x2, 31);
			sum += round_away(pw * longint'(COEF[k]), 31);
		end
		res = round_away(sum, 2);
		if (res > 64'sd1073741823)
			res = 64'sd1073741823;
		if (res < -64'sd1073741824)
			res = -64'sd1073741824;
		return res[30:0];
	endfunction

	assign pending_count = log_queue.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count <= 0;
			log_queue.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (log_queue.size() == 0) begin
					$error("unexpected word: log_value=%0d", rsp.log_value);
					fail_count <= fail_count + 1;
				end else if (rsp.log_value !== log_queue[0]) begin
					$error("log_value: expected %0d actual %0d", log_queue[0], rsp.log_value);
					fail_count <= fail_count + 1;
				end
				if (log_queue.size() != 0)
					void'(log_queue.pop_front());
			end
			if (req.valid && req.ready)
				log_queue.push_back(series_log(req.operand));
		end
	end
endmodule

[tb/sv/natural_log_series_core_test.sv]
`timescale 1ns / 100ps
module natural_log_series_core_test;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count;
	int pending_count;
	int sent;
	bit held;

	nls_in_if req();
	nls_out_if rsp();

	natural_log_series_core u_dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	natural_log_series_checker u_checker (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	logic [15:0] directed_words[$] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd65535, 16'd65534,
		16'd32768, 16'd32767, 16'hAAAA, 16'h5555, 16'd255, 16'd256, 16'd10, 16'd100,
		16'd1000, 16'd4, 16'd7, 16'd8, 16'hFF00, 16'h00FF};

	always #6 clk = ~clk;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 70);
	endfunction

	function automatic logic [15:0] random_operand();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 15));
			1: return 16'($urandom_range(0, 65535) >> $urandom_range(0, 15));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (held)
				rsp.ready <= 1'b1;
			else
				rsp.ready <= (gap_len() == 0);
		end
	end

	task automatic send_word(input logic [15:0] w);
		int g;
		g = gap_len();
		if (sent > 1100)
			g = 0;
		if (g > 0) begin
			req.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.operand <= w;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sent++;
	endtask

	initial begin
		req.valid <= 1'b0;
		req.operand <= '0;
		held = 0;
		sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_words[i])
			send_word(directed_words[i]);
		req.valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		for (int i = 0; i < 1630; i++) begin
			send_word(random_operand());
			if (i == 800) begin
				req.valid <= 1'b0;
				while (pending_count != 0) @(posedge clk);
			end
			if (i == 1400)
				held = 1;
			if (i == 1500)
				held = 0;
		end
		req.valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#4000000;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
